// ----- design/hsv_to_rgb_converter_core_assert.svh -----
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion forms for the converter RTL.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define HSVRGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must never be seen outside reset
`define HSVRGB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ----- design/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, fixed-point constants, sector codes and shared types.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int HueW     = 9;
	localparam int ChanW    = 8;
	localparam int RemW     = 6;
	localparam int QuotW    = 4;
	localparam int SectorW  = 3;
	localparam int NumW     = 14;
	localparam int ProdW    = ChanW + NumW;

	localparam int SectorDeg = 60;
	localparam int FullScale = 255;
	localparam int Sectors   = 6;
	localparam int Den       = FullScale * SectorDeg;

	// floor(h / 60) = (h * HueRecip) >> HueShift for h below 512
	localparam int HueRecip  = 1093;
	localparam int HueShift  = 16;
	localparam int HueProdW  = 20;

	// floor(2^32 / 15300); the estimate of floor(x / 15300) is exact or one low
	localparam longint DenRecip  = 64'd280716;
	localparam int     DenShift  = 32;
	localparam int     DenRecipW = 19;
	localparam int     EstProdW  = ProdW + DenRecipW;

	typedef logic [SectorW-1:0] sector_t;

	localparam sector_t SEC_RED     = 3'd0;
	localparam sector_t SEC_YELLOW  = 3'd1;
	localparam sector_t SEC_GREEN   = 3'd2;
	localparam sector_t SEC_CYAN    = 3'd3;
	localparam sector_t SEC_BLUE    = 3'd4;
	localparam sector_t SEC_MAGENTA = 3'd5;

	typedef struct packed {
		logic [RemW-1:0] rem;
		sector_t         sector;
	} hue_split_t;

endpackage

// ----- design/hsv_to_rgb_converter_core.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Seven-stage pipeline converting one HSV pixel per clock to 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
//   Drive hue, saturation and brightness with start high; the pixel is taken
//   at the rising edge where start is high and busy is low. busy stays low,
//   so a new pixel can be taken on every clock.
//   When a taken pixel leaves the last stage, done is high for one cycle with
//   red, green and blue valid in that cycle; the receiver takes them then.
//   Throughput is one pixel per cycle; the stage chain is hue split (2),
//   factor numerators (1), product, reciprocal estimate, correction (3)
//   and the sector select (1).
//   Pixels come out in the order they went in, back to back when fed so.
//   The receiver cannot stall the results; nothing is held back.
//   Reset clears the valid bits of all stages; pixels in flight are dropped
//   and done stays low until new pixels reach the last stage.
//   Hue 360 to 511 behaves as hue minus 360; zero saturation gives grey.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core import hsvrgb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [HueW-1:0]  hue,
	input  logic [ChanW-1:0] saturation,
	input  logic [ChanW-1:0] brightness,
	output logic             done,
	output logic [ChanW-1:0] red,
	output logic [ChanW-1:0] green,
	output logic [ChanW-1:0] blue
);

`include "hsv_to_rgb_converter_core_assert.svh"

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	logic [ChanW-1:0] sat_s1, sat_s2;
	logic [ChanW-1:0] bright_s1, bright_s2, bright_s3, bright_s4, bright_s5, bright_s6;
	sector_t          sector_s3, sector_s4, sector_s5, sector_s6;

	hue_split_t       split;
	logic [NumW-1:0]  p_num, q_num, t_num;
	logic [ChanW-1:0] p_val, q_val, t_val;
	logic [ChanW-1:0] red_s7, green_s7, blue_s7;
	logic             accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		sat_s1    <= saturation;
		sat_s2    <= sat_s1;
		bright_s1 <= brightness;
		bright_s2 <= bright_s1;
		bright_s3 <= bright_s2;
		bright_s4 <= bright_s3;
		bright_s5 <= bright_s4;
		bright_s6 <= bright_s5;
		sector_s3 <= split.sector;
		sector_s4 <= sector_s3;
		sector_s5 <= sector_s4;
		sector_s6 <= sector_s5;
	end

	hsvrgb_hue_split u_hue_split (
		.clk   (clk),
		.hue   (hue),
		.split (split)
	);

	hsvrgb_factors u_factors (
		.clk        (clk),
		.split      (split),
		.saturation (sat_s2),
		.p_num      (p_num),
		.q_num      (q_num),
		.t_num      (t_num)
	);

	hsvrgb_ratio u_ratio_p (
		.clk        (clk),
		.brightness (bright_s3),
		.num        (p_num),
		.ratio      (p_val)
	);

	hsvrgb_ratio u_ratio_q (
		.clk        (clk),
		.brightness (bright_s3),
		.num        (q_num),
		.ratio      (q_val)
	);

	hsvrgb_ratio u_ratio_t (
		.clk        (clk),
		.brightness (bright_s3),
		.num        (t_num),
		.ratio      (t_val)
	);

	always_ff @(posedge clk) begin
		case (sector_s6)
			SEC_RED: begin
				red_s7   <= bright_s6;
				green_s7 <= t_val;
				blue_s7  <= p_val;
			end
			SEC_YELLOW: begin
				red_s7   <= q_val;
				green_s7 <= bright_s6;
				blue_s7  <= p_val;
			end
			SEC_GREEN: begin
				red_s7   <= p_val;
				green_s7 <= bright_s6;
				blue_s7  <= t_val;
			end
			SEC_CYAN: begin
				red_s7   <= p_val;
				green_s7 <= q_val;
				blue_s7  <= bright_s6;
			end
			SEC_BLUE: begin
				red_s7   <= t_val;
				green_s7 <= p_val;
				blue_s7  <= bright_s6;
			end
			default: begin
				red_s7   <= bright_s6;
				green_s7 <= p_val;
				blue_s7  <= q_val;
			end
		endcase
	end

	assign done  = valid_s7;
	assign red   = red_s7;
	assign green = green_s7;
	assign blue  = blue_s7;

	`HSVRGB_ASSERT_IMP(a_done_follows_start, clk, arst_n, done, $past(accept, 7), "result without a transaction seven cycles earlier")
	`HSVRGB_ASSERT_NEVER(a_not_above_value, clk, arst_n, done && (red > $past(brightness, 7) || green > $past(brightness, 7) || blue > $past(brightness, 7)), "channel above brightness")
	`HSVRGB_ASSERT_IMP(a_grey, clk, arst_n, done && $past(saturation, 7) == '0, red == $past(brightness, 7) && green == red && blue == red, "zero saturation not grey")

endmodule

// ----- design/hsvrgb_hue_split.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB hue split
// Two-stage split of the hue into sector and remainder within the sector.
// ----------------------------------------------------------------------------
module hsvrgb_hue_split import hsvrgb_pkg::*; (
	input  logic             clk,
	input  logic [HueW-1:0]  hue,
	output hue_split_t       split
);

	logic [HueProdW-1:0] hue_prod;
	logic [HueW-1:0]     hue_s1;
	logic [QuotW-1:0]    quot_s1;
	logic [HueW-1:0]     base;
	logic [HueW-1:0]     rem_full;
	hue_split_t          split_s2;

	assign hue_prod = HueProdW'(hue) * HueProdW'(HueRecip);

	always_ff @(posedge clk) begin
		hue_s1  <= hue;
		quot_s1 <= hue_prod[HueShift +: QuotW];
	end

	assign base     = HueW'(quot_s1) * HueW'(SectorDeg);
	assign rem_full = hue_s1 - base;

	always_ff @(posedge clk) begin
		split_s2.rem <= rem_full[RemW-1:0];
		if (quot_s1 >= QuotW'(Sectors)) begin
			split_s2.sector <= SectorW'(quot_s1 - QuotW'(Sectors));
		end else begin
			split_s2.sector <= SectorW'(quot_s1);
		end
	end

	assign split = split_s2;

endmodule

// ----- design/hsvrgb_factors.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB factor numerators
// Numerators of p, q and t over the common denominator 255 * 60.
// ----------------------------------------------------------------------------
module hsvrgb_factors import hsvrgb_pkg::*; (
	input  logic             clk,
	input  hue_split_t       split,
	input  logic [ChanW-1:0] saturation,
	output logic [NumW-1:0]  p_num,
	output logic [NumW-1:0]  q_num,
	output logic [NumW-1:0]  t_num
);

	logic [RemW:0]     rem_inv;
	logic [NumW-1:0]   sp;
	logic [NumW-1:0]   sq;
	logic [NumW-1:0]   st;
	logic [NumW-1:0]   p_num_s3;
	logic [NumW-1:0]   q_num_s3;
	logic [NumW-1:0]   t_num_s3;

	assign rem_inv = (RemW+1)'(SectorDeg) - {1'b0, split.rem};
	assign sp      = NumW'(saturation) * NumW'(SectorDeg);
	assign sq      = NumW'(split.rem) * NumW'(saturation);
	assign st      = NumW'(rem_inv) * NumW'(saturation);

	always_ff @(posedge clk) begin
		p_num_s3 <= NumW'(Den) - sp;
		q_num_s3 <= NumW'(Den) - sq;
		t_num_s3 <= NumW'(Den) - st;
	end

	assign p_num = p_num_s3;
	assign q_num = q_num_s3;
	assign t_num = t_num_s3;

endmodule

// ----- design/hsvrgb_ratio.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB scaled ratio
// Three-stage floor(v * num / 15300) by reciprocal estimate and correction.
// ----------------------------------------------------------------------------
module hsvrgb_ratio import hsvrgb_pkg::*; (
	input  logic             clk,
	input  logic [ChanW-1:0] brightness,
	input  logic [NumW-1:0]  num,
	output logic [ChanW-1:0] ratio
);

	logic [ProdW-1:0]    prod_s4;
	logic [EstProdW-1:0] est_full;
	logic [ProdW-1:0]    prod_s5;
	logic [ChanW-1:0]    est_s5;
	logic [ChanW:0]      est_inc;
	logic [ProdW-1:0]    est_back;
	logic [ChanW-1:0]    ratio_s6;

	always_ff @(posedge clk) begin
		prod_s4 <= ProdW'(brightness) * ProdW'(num);
	end

	assign est_full = EstProdW'(prod_s4) * EstProdW'(DenRecip);

	always_ff @(posedge clk) begin
		prod_s5 <= prod_s4;
		est_s5  <= est_full[DenShift +: ChanW];
	end

	assign est_inc  = {1'b0, est_s5} + (ChanW+1)'(1);
	assign est_back = ProdW'(est_inc) * ProdW'(Den);

	always_ff @(posedge clk) begin
		if (est_back <= prod_s5) begin
			ratio_s6 <= est_inc[ChanW-1:0];
		end else begin
			ratio_s6 <= est_s5;
		end
	end

	assign ratio = ratio_s6;

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives pixels into the converter core and checks every RGB result against
// a local six-sector predictor: a directed set of corner pixels first, then
// random pixels under three sender idle rates.
// ----------------------------------------------------------------------------
module tb_top import hsvrgb_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ClkHalf     = 2;
	localparam int ResetCycles = 7;
	localparam int DrainCycles = 12;
	localparam int CycleLimit  = 200000;
	localparam int MaxReports  = 10;
	localparam int BurstLen    = 40;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} rgb_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [HueW-1:0]  hue = '0;
	logic [ChanW-1:0] saturation = '0;
	logic [ChanW-1:0] brightness = '0;
	logic             done;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;

	rgb_t pending_rgb[$];
	int   sender_idle_pct = 0;
	int   pixels_sent = 0;
	int   pixels_checked = 0;
	int   grey_pixels = 0;
	int   wrapped_hues = 0;
	int   mismatch_count = 0;
	int   fail_count = 0;
	int   cycle_count = 0;

	hsv_to_rgb_converter_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	initial begin
		forever #ClkHalf clk = ~clk;
	end

	function automatic rgb_t hsv_to_rgb(input logic [HueW-1:0] h, input logic [ChanW-1:0] s,
		input logic [ChanW-1:0] v);
		rgb_t             px;
		sector_t          sec;
		int               rem;
		int               p;
		int               q;
		int               t;
		logic [ChanW-1:0] p8;
		logic [ChanW-1:0] q8;
		logic [ChanW-1:0] t8;
		if (s == 0) begin
			px = '{red: v, green: v, blue: v};
		end else begin
			sec = sector_t'((int'(h) / SectorDeg) % Sectors);
			rem = int'(h) % SectorDeg;
			p = int'(v) * (Den - SectorDeg * int'(s)) / Den;
			q = int'(v) * (Den - rem * int'(s)) / Den;
			t = int'(v) * (Den - (SectorDeg - rem) * int'(s)) / Den;
			p8 = ChanW'(p);
			q8 = ChanW'(q);
			t8 = ChanW'(t);
			case (sec)
				SEC_RED:    px = '{red: v, green: t8, blue: p8};
				SEC_YELLOW: px = '{red: q8, green: v, blue: p8};
				SEC_GREEN:  px = '{red: p8, green: v, blue: t8};
				SEC_CYAN:   px = '{red: p8, green: q8, blue: v};
				SEC_BLUE:   px = '{red: t8, green: p8, blue: v};
				default:    px = '{red: v, green: p8, blue: q8};
			endcase
		end
		return px;
	endfunction

	task automatic send_pixel(input int h, input int s, input int v);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start      <= 1'b0;
			hue        <= HueW'($urandom);
			saturation <= ChanW'($urandom);
			brightness <= ChanW'($urandom);
			@(posedge clk);
		end
		start      <= 1'b1;
		hue        <= HueW'(h);
		saturation <= ChanW'(s);
		brightness <= ChanW'(v);
		do @(posedge clk); while (busy !== 1'b0);
		pending_rgb = {pending_rgb, hsv_to_rgb(HueW'(h), ChanW'(s), ChanW'(v))};
		pixels_sent++;
		if (s == 0)
			grey_pixels++;
		if (h >= Sectors * SectorDeg)
			wrapped_hues++;
	endtask

	task automatic test_sector_edges();
		int i;
		sender_idle_pct = 0;
		for (i = 0; i < Sectors; i++) begin
			send_pixel(i * SectorDeg, 255, 255);
			send_pixel(i * SectorDeg + SectorDeg - 1, 255 - 40 * i, 255 - 20 * i);
		end
		send_pixel(1, 1, 255);
		send_pixel(90, 255, 0);
		send_pixel(200, 170, 85);
	endtask

	task automatic test_grey_pixels();
		send_pixel(30, 0, 200);
		send_pixel(0, 0, 0);
		send_pixel(255, 0, 255);
		send_pixel(511, 0, 1);
	endtask

	task automatic test_wrapped_hues();
		send_pixel(360, 255, 255);
		send_pixel(420, 255, 200);
		send_pixel(479, 128, 255);
		send_pixel(511, 255, 255);
	endtask

	task automatic test_random_pixels(input int idle_pct, input int count);
		int i;
		int h;
		int s;
		int v;
		for (i = 0; i < count; i++) begin
			if (i % BurstLen == 0)
				sender_idle_pct = ($urandom_range(3) == 0) ? 0 : idle_pct;
			case ($urandom_range(19))
				0:       h = SectorDeg * $urandom_range(Sectors - 1);
				1:       h = SectorDeg * $urandom_range(1, Sectors) - 1;
				2, 3:    h = $urandom_range(360, 511);
				default: h = $urandom_range(359);
			endcase
			case ($urandom_range(9))
				0:       s = 0;
				1:       s = 255;
				2:       s = 1;
				default: s = $urandom_range(255);
			endcase
			case ($urandom_range(9))
				0:       v = 0;
				1:       v = 255;
				default: v = $urandom_range(255);
			endcase
			send_pixel(h, s, v);
		end
	endtask

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_rgb.size() == 0) begin
				fail_count++;
				if (mismatch_count++ < MaxReports)
					$display("unexpected result: red %0d green %0d blue %0d", red, green, blue);
			end else begin
				want = pending_rgb.pop_front();
				pixels_checked++;
				if (red !== want.red || green !== want.green || blue !== want.blue) begin
					fail_count++;
					if (mismatch_count++ < MaxReports)
						$display("result %0d mismatch: exp rgb %0d %0d %0d, got %0d %0d %0d",
							pixels_checked, want.red, want.green, want.blue, red, green, blue);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sector_edges();
		test_grey_pixels();
		test_wrapped_hues();
		test_random_pixels(33, 560);
		test_random_pixels(71, 560);
		test_random_pixels(0, 560);

		start <= 1'b0;
		while (pending_rgb.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		fail_count += pending_rgb.size();

		$display("Checked %0d of %0d pixels: %0d grey, %0d with hue past 359.",
			pixels_checked, pixels_sent, grey_pixels, wrapped_hues);
		$display("Sender idle rates 33%%, 71%% and none; %0d mismatches.", mismatch_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
